// ----- sv/assert_macros.svh -----
// Assertion helpers for the RTL files; rgba_bracket_blend includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define RBB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, but checked during reset too.
`define RBB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/rbb_pkg.sv -----
// ----------------------------------------------------------------------------
// rbb_pkg
// Types and codes shared by the RGBA blend datapath.
// ----------------------------------------------------------------------------
package rbb_pkg;

    localparam int CHAN_W = 16;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef enum logic [2:0] {
        MODE_ADD      = 3'd0,
        MODE_SUBTRACT = 3'd1,
        MODE_MULTIPLY = 3'd2,
        MODE_DIVIDE   = 3'd3,
        MODE_BLEND    = 3'd4,
        MODE_SOLID    = 3'd5
    } mode_t;

endpackage

// ----- sv/rgba_bracket_blend.sv -----
// ----------------------------------------------------------------------------
// rgba_bracket_blend
// Fixed-point RGBA compositor: four channel lanes and a merged output word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | bg_red..bg_alpha, fg_red..fg_alpha
//  out     | output    | out_valid/out_stall| out_red..out_alpha
//  cfg     | input     | cfg_valid/cfg_ready| cfg_data (blend mode)
//
// One pixel word per cycle while out_stall is low; the restoring divider
// resolves one quotient bit per divider stage.
// Reset clears the stage valid bits and sets the mode to add.
// Stalls collapse bubbles: a stage loads whenever it is empty or the stage
// after it moves, so a held output word does not stop upstream stages from
// filling. cfg_ready is always high.
module rgba_bracket_blend #(
    parameter int FRAC_BITS = 15
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  rbb_pkg::chan_t  bg_red,
    input  rbb_pkg::chan_t  bg_green,
    input  rbb_pkg::chan_t  bg_blue,
    input  rbb_pkg::chan_t  bg_alpha,
    input  rbb_pkg::chan_t  fg_red,
    input  rbb_pkg::chan_t  fg_green,
    input  rbb_pkg::chan_t  fg_blue,
    input  rbb_pkg::chan_t  fg_alpha,
    output logic            out_valid,
    input  logic            out_stall,
    output rbb_pkg::chan_t  out_red,
    output rbb_pkg::chan_t  out_green,
    output rbb_pkg::chan_t  out_blue,
    output rbb_pkg::chan_t  out_alpha,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_data
);
    import rbb_pkg::*;

    `include "assert_macros.svh"

    // Lane stages 0..FRAC_BITS, then the merged output register.
    localparam int DEPTH = FRAC_BITS + 2;

    mode_t              blend_mode_reg;
    logic [DEPTH-1:0]   valid_reg;
    logic [DEPTH:0]     rdy;
    chan_t              lane_res [4];
    chan_t              out_reg  [4];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            blend_mode_reg <= MODE_ADD;
        else if (cfg_valid && cfg_ready)
            blend_mode_reg <= mode_t'(cfg_data);
    end

    // Ready ripples back: a stage may load if empty or if its successor loads.
    always_comb
    begin
        rdy[DEPTH] = !out_stall;
        for (int k = DEPTH - 1; k >= 0; k--)
            rdy[k] = !valid_reg[k] || rdy[k+1];
    end

    assign in_stall  = !rdy[0];
    assign out_valid = valid_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (rdy[0])
                valid_reg[0] <= in_valid;
            for (int k = 1; k < DEPTH; k++)
            begin
                if (rdy[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    chan_t lane_bg [4];
    chan_t lane_fg [4];

    always_comb
    begin
        lane_bg[0] = bg_red;
        lane_bg[1] = bg_green;
        lane_bg[2] = bg_blue;
        lane_bg[3] = bg_alpha;
        lane_fg[0] = fg_red;
        lane_fg[1] = fg_green;
        lane_fg[2] = fg_blue;
        lane_fg[3] = fg_alpha;
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        rbb_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk      (clk),
            .stage_en (rdy[FRAC_BITS:0]),
            .mode     (blend_mode_reg),
            .bg       (lane_bg[i]),
            .fg       (lane_fg[i]),
            .fg_alpha (fg_alpha),
            .result   (lane_res[i])
        );
    end

    // Merge the four lane results into the output word; hold while stalled.
    always_ff @(posedge clk)
    begin
        if (rdy[DEPTH-1])
        begin
            for (int i = 0; i < 4; i++)
                out_reg[i] <= lane_res[i];
        end
    end

    assign out_red   = out_reg[0];
    assign out_green = out_reg[1];
    assign out_blue  = out_reg[2];
    assign out_alpha = out_reg[3];

    // A stalled input means every stage holds a word, the output included.
    `RBB_ASSERT(a_stall_full, in_stall |-> (valid_reg == '1), "input stalled with a bubble")
    // An accepted word always lands in the capture stage.
    `RBB_ASSERT(a_accept_lands, (in_valid && !in_stall) |=> valid_reg[0], "accepted word lost")
    // A mode write takes effect on the next cycle.
    `RBB_ASSERT(a_mode_write, (cfg_valid && cfg_ready) |=> (blend_mode_reg == $past(cfg_data)),
                "mode write not captured")

endmodule

// ----- sv/rbb_lane.sv -----
// ----------------------------------------------------------------------------
// rbb_lane
// One channel of the blend: saturate, multiply, restoring divide, select.
// ----------------------------------------------------------------------------
module rbb_lane #(
    parameter int FRAC_BITS = 15
) (
    input  logic                 clk,
    input  logic [FRAC_BITS:0]   stage_en,
    input  rbb_pkg::mode_t       mode,
    input  rbb_pkg::chan_t       bg,
    input  rbb_pkg::chan_t       fg,
    input  rbb_pkg::chan_t       fg_alpha,
    output rbb_pkg::chan_t       result
);
    import rbb_pkg::*;

    localparam int               PW       = 2 * CHAN_W + 2;
    localparam int               SW       = PW + 2;
    localparam logic [CHAN_W:0]  ONE      = (CHAN_W + 1)'(1) << FRAC_BITS;
    localparam logic [CHAN_W:0]  HALF     = ONE >> 1;
    localparam chan_t            CHAN_MAX = (FRAC_BITS >= CHAN_W) ? '1 : chan_t'(ONE);

    function automatic chan_t sat(input chan_t x);
        return (x > CHAN_MAX) ? CHAN_MAX : x;
    endfunction

    mode_t                      mode_reg [FRAC_BITS+1];
    chan_t                      b_reg    [FRAC_BITS+1];
    chan_t                      f_reg    [FRAC_BITS+1];
    logic signed [PW-1:0]       prod_reg [FRAC_BITS+1];
    chan_t                      rem_reg  [FRAC_BITS+1];
    logic [FRAC_BITS-1:0]       quo_reg  [FRAC_BITS+1];

    chan_t                      bs;
    chan_t                      fs;
    chan_t                      fas;
    logic signed [CHAN_W:0]     op_a;
    logic signed [CHAN_W:0]     op_b;
    logic signed [PW-1:0]       prod_next;

    always_comb
    begin
        bs = sat(bg);
        fs = sat(fg);
        fas = sat(fg_alpha);
        if (mode == MODE_BLEND)
        begin
            op_a = $signed({1'b0, fs}) - $signed({1'b0, bs});
            op_b = $signed({1'b0, fas});
        end
        else
        begin
            op_a = $signed({1'b0, bs});
            op_b = $signed({1'b0, fs});
        end
        prod_next = PW'(op_a * op_b);
    end

    // Capture stage: saturated operands and the one product.
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            mode_reg[0] <= mode;
            b_reg[0]    <= bs;
            f_reg[0]    <= fs;
            prod_reg[0] <= prod_next;
            rem_reg[0]  <= bs;
            quo_reg[0]  <= '0;
        end
    end

    // One quotient bit per stage; only used in divide mode when bg < fg.
    for (genvar k = 1; k <= FRAC_BITS; k++)
    begin : g_div
        logic [CHAN_W:0] t;
        logic            ge;
        always_comb
        begin
            t  = {rem_reg[k-1], 1'b0};
            ge = (t >= {1'b0, f_reg[k-1]});
        end
        always_ff @(posedge clk)
        begin
            if (stage_en[k])
            begin
                mode_reg[k] <= mode_reg[k-1];
                b_reg[k]    <= b_reg[k-1];
                f_reg[k]    <= f_reg[k-1];
                prod_reg[k] <= prod_reg[k-1];
                rem_reg[k]  <= ge ? CHAN_W'(t - {1'b0, f_reg[k-1]}) : CHAN_W'(t);
                quo_reg[k]  <= {quo_reg[k-1][FRAC_BITS-2:0], ge};
            end
        end
    end

    chan_t                  b;
    chan_t                  f;
    logic signed [SW-1:0]   sum;
    logic [SW-1:0]          val;

    always_comb
    begin
        b   = b_reg[FRAC_BITS];
        f   = f_reg[FRAC_BITS];
        sum = $signed(SW'({b, {FRAC_BITS{1'b0}}})) + SW'(prod_reg[FRAC_BITS])
              + $signed(SW'(HALF));
        case (mode_reg[FRAC_BITS])
            MODE_SUBTRACT: val = (b > f) ? SW'(b - f) : '0;
            MODE_MULTIPLY: val = SW'(prod_reg[FRAC_BITS] + PW'(HALF)) >> FRAC_BITS;
            MODE_DIVIDE:
            begin
                if (f == '0)
                    val = (b != '0) ? SW'(ONE) : '0;
                else if (b >= f)
                    val = SW'(ONE);
                else
                    val = SW'(quo_reg[FRAC_BITS]);
            end
            MODE_BLEND:    val = SW'(sum >>> FRAC_BITS);
            MODE_SOLID:    val = SW'(f);
            default:       val = SW'(b) + SW'(f);
        endcase
        result = (val > SW'(CHAN_MAX)) ? CHAN_MAX : val[CHAN_W-1:0];
    end

endmodule
